FILE: hdl/first_fit_heap_allocator_assert.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_W            = 13;
	localparam int REQ_W             = 12;
	localparam int HEAP_BYTES_DEF    = 4096;
	localparam int HEADER_BYTES_DEF  = 1;
	localparam int MAX_EXTENTS_DEF   = 16;
	localparam int MAX_BLOCKS_DEF    = 16;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_FIT  = 2'd1,
		STAT_UNKNOWN = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_BSCAN,
		S_XSCAN,
		S_MERGE,
		S_SHDN,
		S_SHUP,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t                opcode;
		logic [REQ_W-1:0]   request_size;
		logic [ADDR_W-1:0]  release_address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		status_t            status;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  start;
		logic [ADDR_W-1:0]  len;
	} ext_t;

endpackage

FILE: hdl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with a free-extent table and a live-block table.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) takes one request item: allocate
//   request_size bytes, or release a user address. rsp channel
//   (rsp_valid/rsp_stall/rsp) returns one item per request: address, status.
//   cfg_we/cfg_wdata writes the heap limit (clamped) and reinitializes the heap.
//   One request is worked at a time. Both tables live in RAMs with registered
//   reads and are walked one entry per cycle:
//     allocate: scan the extents up to the first that fits, then shift the
//       extents above it down when it empties; a full block table answers
//       without a walk.
//     release: look up the block table, then search the extents, then merge
//       and shift extents on merge-both or insert.
//   After reset or a config write the S_INIT state rewrites extent 0 before the
//   next item is taken. A finished item waits in the rsp register; while
//   rsp_stall holds it, the next command may be taken and worked, and its
//   result waits internally until the register frees.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int MAX_EXTENTS  = ffha_pkg::MAX_EXTENTS_DEF,
	parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  ffha_pkg::cmd_t              cmd,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output ffha_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [ffha_pkg::ADDR_W-1:0] cfg_wdata
);

	localparam int AW  = ffha_pkg::ADDR_W;
	localparam int XW  = $clog2(MAX_EXTENTS);
	localparam int BW  = $clog2(MAX_BLOCKS);
	localparam int CW  = $clog2(MAX_EXTENTS + 1);
	localparam int BCW = $clog2(MAX_BLOCKS + 1);
	localparam int SW  = (CW > BCW) ? CW : BCW;
	localparam logic [16:0]   HEAP_MAX = 17'(HEAP_BYTES);
	localparam logic [AW-1:0] HEAP_RST = (HEAP_BYTES < 4096) ? AW'(HEAP_BYTES) : AW'(4096);
	localparam logic [AW:0]   HDR      = (AW+1)'(HEADER_BYTES);

	ffha_pkg::ext_t x_mem [MAX_EXTENTS];
	ffha_pkg::ext_t b_mem [MAX_BLOCKS];

	ffha_pkg::state_t state_q, state_d;
	logic [SW-1:0]    cnt_q, idx_s1, p_q;
	logic             rd_s1, rd_go;
	ffha_pkg::op_t    op_q;
	logic [AW-1:0]    total_q, uaddr_q, s_q, len_q, heap_limit_q;
	logic [BW-1:0]    slot_q;
	ffha_pkg::ext_t   cur_q, prev_q, x_rd, b_rd;
	logic             have_cur_q, init_pend_q;
	logic [CW-1:0]    x_count_q;
	logic [MAX_BLOCKS-1:0] bvalid_q;
	ffha_pkg::rsp_t   res_q, rsp_q;
	logic             rsp_valid_q;

	logic             x_we, b_we;
	logic [XW-1:0]    x_waddr, x_raddr;
	logic [BW-1:0]    b_waddr, b_raddr;
	ffha_pkg::ext_t   x_wdata, b_wdata;

	logic             accept, free_any, b_match, x_fit, x_empty, x_above;
	logic             top, bot, scan_end;
	logic [BW-1:0]    free_idx;
	logic [SW-1:0]    count_w;
	logic [AW-1:0]    total_in, clamp;

	assign count_w  = SW'(x_count_q);
	assign accept   = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ffha_pkg::S_IDLE) || init_pend_q || cfg_we;
	assign total_in = AW'({1'b0, cmd.request_size} + HDR[AW-1:0]);

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!bvalid_q[i]) begin
				free_any = 1'b1;
				free_idx = BW'(i);
			end
		end
	end

	always_comb begin
		if (cfg_wdata == '0)
			clamp = AW'(1);
		else if ({4'b0, cfg_wdata} > HEAP_MAX)
			clamp = AW'(HEAP_BYTES);
		else
			clamp = cfg_wdata;
	end

	assign b_match = rd_s1 && bvalid_q[idx_s1[BW-1:0]]
		&& (({1'b0, b_rd.start} + HDR) == {1'b0, uaddr_q});
	assign x_fit   = rd_s1 && (x_rd.len >= total_q);
	assign x_empty = (x_rd.len == total_q) && (total_q != '0);
	assign x_above = rd_s1 && (x_rd.start > s_q);
	assign top = have_cur_q && (({1'b0, s_q} + {1'b0, len_q}) == {1'b0, cur_q.start});
	assign bot = (p_q != '0) && (({1'b0, prev_q.start} + {1'b0, prev_q.len}) == {1'b0, s_q});

	always_comb begin
		unique case (state_q)
			ffha_pkg::S_BSCAN: scan_end = !rd_s1 && (cnt_q == SW'(MAX_BLOCKS));
			ffha_pkg::S_XSCAN: scan_end = !rd_s1 && (cnt_q == count_w);
			ffha_pkg::S_SHDN:  scan_end = !rd_s1 && !(cnt_q < count_w);
			ffha_pkg::S_SHUP:  scan_end = !rd_s1 && (cnt_q == p_q);
			default:           scan_end = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (init_pend_q)
					state_d = ffha_pkg::S_INIT;
				else if (accept) begin
					if (cmd.opcode == ffha_pkg::OP_RELEASE)
						state_d = ffha_pkg::S_BSCAN;
					else if (free_any)
						state_d = ffha_pkg::S_XSCAN;
					else
						state_d = ffha_pkg::S_RESP;
				end
			end
			ffha_pkg::S_INIT: state_d = ffha_pkg::S_IDLE;
			ffha_pkg::S_BSCAN: begin
				if (b_match)
					state_d = (b_rd.len == '0) ? ffha_pkg::S_RESP : ffha_pkg::S_XSCAN;
				else if (scan_end)
					state_d = ffha_pkg::S_RESP;
			end
			ffha_pkg::S_XSCAN: begin
				if (op_q == ffha_pkg::OP_ALLOC) begin
					if (x_fit)
						state_d = x_empty ? ffha_pkg::S_SHDN : ffha_pkg::S_RESP;
					else if (scan_end)
						state_d = ffha_pkg::S_RESP;
				end else if (x_above || scan_end)
					state_d = ffha_pkg::S_MERGE;
			end
			ffha_pkg::S_MERGE: begin
				if (top && bot)
					state_d = ffha_pkg::S_SHDN;
				else if (top || bot || (count_w >= SW'(MAX_EXTENTS)))
					state_d = ffha_pkg::S_RESP;
				else
					state_d = ffha_pkg::S_SHUP;
			end
			ffha_pkg::S_SHDN: if (scan_end) state_d = ffha_pkg::S_RESP;
			ffha_pkg::S_SHUP: if (scan_end) state_d = ffha_pkg::S_RESP;
			ffha_pkg::S_RESP: if (!rsp_valid_q || !rsp_stall) state_d = ffha_pkg::S_IDLE;
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_go   = 1'b0;
		x_raddr = cnt_q[XW-1:0];
		b_raddr = cnt_q[BW-1:0];
		x_we    = 1'b0;
		x_waddr = '0;
		x_wdata = '0;
		b_we    = 1'b0;
		b_waddr = slot_q;
		b_wdata = '{start: x_rd.start, len: total_q};
		unique case (state_q)
			ffha_pkg::S_INIT: begin
				x_we    = 1'b1;
				x_wdata = '{start: '0, len: heap_limit_q};
			end
			ffha_pkg::S_BSCAN: rd_go = (cnt_q < SW'(MAX_BLOCKS)) && !b_match;
			ffha_pkg::S_XSCAN: begin
				if (op_q == ffha_pkg::OP_ALLOC) begin
					rd_go = (cnt_q < count_w) && !x_fit;
					if (x_fit) begin
						b_we = 1'b1;
						if (!x_empty) begin
							x_we    = 1'b1;
							x_waddr = idx_s1[XW-1:0];
							x_wdata = '{start: x_rd.start + total_q, len: x_rd.len - total_q};
						end
					end
				end else
					rd_go = (cnt_q < count_w) && !x_above;
			end
			ffha_pkg::S_MERGE: begin
				if (top && bot) begin
					x_we    = 1'b1;
					x_waddr = XW'(p_q - SW'(1));
					x_wdata = '{start: prev_q.start, len: prev_q.len + len_q + cur_q.len};
				end else if (top) begin
					x_we    = 1'b1;
					x_waddr = p_q[XW-1:0];
					x_wdata = '{start: s_q, len: cur_q.len + len_q};
				end else if (bot) begin
					x_we    = 1'b1;
					x_waddr = XW'(p_q - SW'(1));
					x_wdata = '{start: prev_q.start, len: prev_q.len + len_q};
				end
			end
			ffha_pkg::S_SHDN: begin
				rd_go = cnt_q < count_w;
				if (rd_s1) begin
					x_we    = 1'b1;
					x_waddr = XW'(idx_s1 - SW'(1));
					x_wdata = x_rd;
				end
			end
			ffha_pkg::S_SHUP: begin
				rd_go   = cnt_q > p_q;
				x_raddr = XW'(cnt_q - SW'(1));
				if (rd_s1) begin
					x_we    = 1'b1;
					x_waddr = idx_s1[XW-1:0];
					x_wdata = x_rd;
				end else if (scan_end) begin
					x_we    = 1'b1;
					x_waddr = p_q[XW-1:0];
					x_wdata = '{start: s_q, len: len_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (x_we)
			x_mem[x_waddr] <= x_wdata;
		x_rd <= x_mem[x_raddr];
		if (b_we)
			b_mem[b_waddr] <= b_wdata;
		b_rd <= b_mem[b_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ffha_pkg::S_IDLE;
			rd_s1        <= 1'b0;
			x_count_q    <= CW'(1);
			bvalid_q     <= '0;
			heap_limit_q <= HEAP_RST;
			init_pend_q  <= 1'b1;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_go;
			if (cfg_we) begin
				heap_limit_q <= clamp;
				init_pend_q  <= 1'b1;
			end else if (state_q == ffha_pkg::S_INIT)
				init_pend_q <= 1'b0;
			if (state_q == ffha_pkg::S_RESP && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ffha_pkg::S_INIT: begin
					x_count_q <= CW'(1);
					bvalid_q  <= '0;
				end
				ffha_pkg::S_BSCAN:
					if (b_match && b_rd.len == '0)
						bvalid_q[idx_s1[BW-1:0]] <= 1'b0;
				ffha_pkg::S_XSCAN:
					if (op_q == ffha_pkg::OP_ALLOC && x_fit)
						bvalid_q[slot_q] <= 1'b1;
				ffha_pkg::S_MERGE:
					if (top || bot)
						bvalid_q[slot_q] <= 1'b0;
				ffha_pkg::S_SHDN:
					if (scan_end)
						x_count_q <= x_count_q - CW'(1);
				ffha_pkg::S_SHUP:
					if (scan_end) begin
						x_count_q        <= x_count_q + CW'(1);
						bvalid_q[slot_q] <= 1'b0;
					end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (rd_go)
			cnt_q <= (state_q == ffha_pkg::S_SHUP) ? cnt_q - SW'(1) : cnt_q + SW'(1);
		idx_s1 <= cnt_q;
		if (state_q == ffha_pkg::S_RESP && (!rsp_valid_q || !rsp_stall))
			rsp_q <= res_q;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				op_q    <= cmd.opcode;
				total_q <= total_in;
				uaddr_q <= cmd.release_address;
				slot_q  <= free_idx;
				cnt_q   <= '0;
				res_q   <= '{address: '0, status: ffha_pkg::STAT_FULL};
			end
			ffha_pkg::S_BSCAN: begin
				if (b_match) begin
					s_q    <= b_rd.start;
					len_q  <= b_rd.len;
					slot_q <= idx_s1[BW-1:0];
					cnt_q  <= '0;
					res_q  <= '{address: '0, status: ffha_pkg::STAT_OK};
				end else if (scan_end)
					res_q <= '{address: '0, status: ffha_pkg::STAT_UNKNOWN};
			end
			ffha_pkg::S_XSCAN: begin
				if (op_q == ffha_pkg::OP_ALLOC) begin
					if (x_fit) begin
						res_q <= '{address: x_rd.start + HDR[AW-1:0],
							status: ffha_pkg::STAT_OK};
						cnt_q <= idx_s1 + SW'(1);
					end else if (scan_end)
						res_q <= '{address: '0, status: ffha_pkg::STAT_NO_FIT};
				end else begin
					if (x_above) begin
						p_q        <= idx_s1;
						cur_q      <= x_rd;
						have_cur_q <= 1'b1;
					end else if (scan_end) begin
						p_q        <= count_w;
						have_cur_q <= 1'b0;
					end else if (rd_s1)
						prev_q <= x_rd;
				end
			end
			ffha_pkg::S_MERGE: begin
				if (top && bot)
					cnt_q <= p_q + SW'(1);
				else if (!top && !bot) begin
					cnt_q <= count_w;
					if (count_w >= SW'(MAX_EXTENTS))
						res_q <= '{address: '0, status: ffha_pkg::STAT_FULL};
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`include "first_fit_heap_allocator_assert.svh"

	`FFHA_ASSERT_NOW(a_count_bound, 1'b1, x_count_q <= CW'(MAX_EXTENTS), "extent count overflow")
	`FFHA_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ffha_pkg::S_IDLE, "accept left idle")
	`FFHA_ASSERT_NOW(a_fail_zero_addr, rsp_valid && rsp.status != ffha_pkg::STAT_OK, rsp.address == '0, "failed item with address")
	`FFHA_ASSERT_NEXT(a_init_count, state_q == ffha_pkg::S_INIT, x_count_q == CW'(1), "init did not set one extent")

endmodule

FILE: tb/sv/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Checks allocate and release responses against a first-fit free-list
// predictor, across several heap sizes and with random idle and stall.
// ----------------------------------------------------------------------------

class heap_scoreboard;
	int ext_start [16];
	int ext_len [16];
	int ext_count;
	int blk_start [16];
	int blk_len [16];
	bit blk_live [16];
	ffha_pkg::rsp_t pending [$];
	int errors;
	int checked;
	int status_seen [4];

	function void reinit(int size);
		ext_count = 1;
		foreach (ext_start[i]) begin
			ext_start[i] = 0;
			ext_len[i] = 0;
			blk_live[i] = 0;
		end
		ext_len[0] = size;
	endfunction

	function void drop_extent(int k);
		for (int i = k; i + 1 < ext_count; i++) begin
			ext_start[i] = ext_start[i + 1];
			ext_len[i] = ext_len[i + 1];
		end
		ext_count--;
	endfunction

	function ffha_pkg::rsp_t carve(int req);
		ffha_pkg::rsp_t r;
		int slot, k, total;
		r = '{address: '0, status: ffha_pkg::STAT_OK};
		total = req + 1;
		slot = 0;
		while (slot < 16 && blk_live[slot]) slot++;
		if (slot == 16) begin
			r.status = ffha_pkg::STAT_FULL;
			return r;
		end
		k = 0;
		while (k < ext_count && ext_len[k] < total) k++;
		if (k == ext_count) begin
			r.status = ffha_pkg::STAT_NO_FIT;
			return r;
		end
		blk_start[slot] = ext_start[k];
		blk_len[slot] = total;
		blk_live[slot] = 1;
		r.address = ffha_pkg::ADDR_W'(ext_start[k] + 1);
		ext_start[k] += total;
		ext_len[k] -= total;
		if (ext_len[k] == 0) drop_extent(k);
		return r;
	endfunction

	function ffha_pkg::rsp_t give_back(int uaddr);
		ffha_pkg::rsp_t r;
		int slot, p, s, len;
		bit top, bot;
		r = '{address: '0, status: ffha_pkg::STAT_OK};
		slot = 0;
		while (slot < 16 && !(blk_live[slot] && blk_start[slot] + 1 == uaddr)) slot++;
		if (slot == 16) begin
			r.status = ffha_pkg::STAT_UNKNOWN;
			return r;
		end
		s = blk_start[slot];
		len = blk_len[slot];
		p = 0;
		while (p < ext_count && ext_start[p] <= s) p++;
		top = (p < ext_count) && (s + len == ext_start[p]);
		bot = (p > 0) && (ext_start[p - 1] + ext_len[p - 1] == s);
		if (top && bot) begin
			ext_len[p - 1] += len + ext_len[p];
			drop_extent(p);
		end else if (top) begin
			ext_start[p] = s;
			ext_len[p] += len;
		end else if (bot) begin
			ext_len[p - 1] += len;
		end else begin
			if (ext_count >= 16) begin
				r.status = ffha_pkg::STAT_FULL;
				return r;
			end
			for (int i = ext_count; i > p; i--) begin
				ext_start[i] = ext_start[i - 1];
				ext_len[i] = ext_len[i - 1];
			end
			ext_start[p] = s;
			ext_len[p] = len;
			ext_count++;
		end
		blk_live[slot] = 0;
		return r;
	endfunction

	function void note(ffha_pkg::cmd_t c);
		if (c.opcode == ffha_pkg::OP_ALLOC) pending.push_back(carve(int'(c.request_size)));
		else pending.push_back(give_back(int'(c.release_address)));
	endfunction

	task report(string what, int got, int want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	task check(ffha_pkg::rsp_t r);
		ffha_pkg::rsp_t e;
		if (pending.size() == 0) begin
			report("unexpected item, address", int'(r.address), 0);
			return;
		end
		e = pending.pop_front();
		checked++;
		status_seen[e.status]++;
		if (r.address !== e.address) report("address", int'(r.address), int'(e.address));
		if (r.status !== e.status) report("status", int'(r.status), int'(e.status));
	endtask

	function int live_addr();
		int n, pick;
		n = 0;
		foreach (blk_live[i]) if (blk_live[i]) n++;
		if (n == 0) return -1;
		pick = $urandom_range(n - 1);
		foreach (blk_live[i]) if (blk_live[i]) begin
			if (pick == 0) return blk_start[i] + 1;
			pick--;
		end
		return -1;
	endfunction
endclass

module first_fit_heap_allocator_tb;

	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_stall;
	ffha_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	ffha_pkg::rsp_t rsp;
	logic cfg_we = 0;
	logic [ffha_pkg::ADDR_W-1:0] cfg_wdata = '0;

	heap_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int heap_now = 4096;

	first_fit_heap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) sb.check(rsp);
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task send(ffha_pkg::op_t op, int req, int addr);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 0;
			@(posedge clk);
		end
		cmd <= '{opcode: op, request_size: req[ffha_pkg::REQ_W-1:0],
			release_address: addr[ffha_pkg::ADDR_W-1:0]};
		cmd_valid <= 1;
		do @(posedge clk); while (cmd_stall);
		sb.note(cmd);
	endtask

	task drain();
		cmd_valid <= 0;
		wait (sb.pending.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task write_heap(int v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v[ffha_pkg::ADDR_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		heap_now = (v == 0) ? 1 : (v > 4096 ? 4096 : v);
		sb.reinit(heap_now);
	endtask

	task random_item();
		int a, roll;
		roll = $urandom_range(99);
		a = sb.live_addr();
		if (roll < 45 && a >= 0)
			send(ffha_pkg::OP_RELEASE, $urandom_range(4095), a);
		else if (roll < 55)
			send(ffha_pkg::OP_RELEASE, $urandom_range(4095), $urandom_range(8191));
		else if (roll < 62)
			send(ffha_pkg::OP_ALLOC, $urandom_range(4095), $urandom_range(8191));
		else
			send(ffha_pkg::OP_ALLOC, $urandom_range(heap_now / 6 + 1), $urandom_range(8191));
	endtask

	initial begin
		int cfgs [6];
		cfgs = '{0, 8191, 200, 64, 4096, 1};
		sb.reinit(4096);
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: whole-heap alloc, no fit, unknown releases, release by insert
		send(ffha_pkg::OP_ALLOC, 4095, 0);
		send(ffha_pkg::OP_RELEASE, 0, 0);
		send(ffha_pkg::OP_RELEASE, 0, 8191);
		for (int i = 0; i < 16; i++) send(ffha_pkg::OP_ALLOC, 9, 0);
		send(ffha_pkg::OP_ALLOC, 0, 0);
		send(ffha_pkg::OP_RELEASE, 0, 11);
		send(ffha_pkg::OP_RELEASE, 0, 31);
		send(ffha_pkg::OP_RELEASE, 0, 21);
		send(ffha_pkg::OP_RELEASE, 0, 1);
		send(ffha_pkg::OP_RELEASE, 0, 151);
		send(ffha_pkg::OP_ALLOC, 4095, 0);

		cfgs[2] = $urandom_range(1, 8191);
		for (int seg = 0; seg < 6; seg++) begin
			write_heap(cfgs[seg]);
			send_idle_pct = (seg < 2) ? 6 : (seg < 4 ? 72 : 0);
			recv_stall_pct = (seg < 2) ? 72 : (seg < 4 ? 6 : 0);
			for (int n = 0; n < 150; n++) begin
				random_item();
				if (seg == 3 && n == 75) drain();
			end
		end
		drain();
		$display("Checked %0d responses over six heap sizes: ok %0d, no fit %0d,",
			sb.checked, sb.status_seen[ffha_pkg::STAT_OK],
			sb.status_seen[ffha_pkg::STAT_NO_FIT]);
		$display("unknown release %0d, table full %0d",
			sb.status_seen[ffha_pkg::STAT_UNKNOWN], sb.status_seen[ffha_pkg::STAT_FULL]);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
